// ===== sv/dhoat_pkg.sv =====
// Shared types and constants for the double-hashing open-address table.
package dhoat_pkg;

	localparam int KEY_BYTES  = 8;
	localparam int KEY_W      = 64;
	localparam int LEN_W      = 4;
	localparam int VALUE_BITS = 32;
	localparam int SIZE_W     = 7;
	localparam int ENTRY_W    = VALUE_BITS + LEN_W + KEY_W + 2;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam int LOAD_NUM = 11;
	localparam int LOAD_DEN = 16;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	localparam logic [1:0] RES_OK      = 2'd0;
	localparam logic [1:0] RES_MISS    = 2'd1;
	localparam logic [1:0] RES_EXHAUST = 2'd2;
	localparam logic [1:0] RES_REFUSED = 2'd3;

	localparam logic [1:0] SLOT_EMPTY = 2'd0;
	localparam logic [1:0] SLOT_FULL  = 2'd1;
	localparam logic [1:0] SLOT_DEAD  = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_HASH, ST_FINAL, ST_DIV,
		ST_PINIT, ST_PRD, ST_PEV, ST_WR, ST_DONE
	} state_t;

	typedef struct packed {
		logic clr_en;
		logic load_in;
		logic hash_step;
		logic hash_final;
		logic div_step;
		logic probe_init;
		logic probe_rd;
		logic probe_ev;
		logic commit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic skip;
		logic hash_done;
		logic div_done;
		logic probe_stop;
		logic out_free;
	} sts_t;

endpackage

// ===== sv/dhoat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dhoat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== sv/dhoat_ctrl.sv =====
// Controller state machine sequencing clear, hash, reduce, probe and commit.
module dhoat_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dhoat_pkg::sts_t sts,
	output dhoat_pkg::cmd_t cmd
);
	import dhoat_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				if (sts.skip) begin
					state_d = ST_DONE;
				end else if (sts.hash_done) begin
					state_d = ST_FINAL;
				end else begin
					cmd.hash_step = 1'b1;
				end
			end
			ST_FINAL: begin
				cmd.hash_final = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = ST_PINIT;
			end
			ST_PINIT: begin
				cmd.probe_init = 1'b1;
				state_d = ST_PRD;
			end
			ST_PRD: begin
				cmd.probe_rd = 1'b1;
				state_d = ST_PEV;
			end
			ST_PEV: begin
				cmd.probe_ev = 1'b1;
				state_d = sts.probe_stop ? ST_WR : ST_PRD;
			end
			ST_WR: begin
				cmd.commit = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== sv/dhoat_dp.sv =====
// Datapath: hash units, serial reducers, probe walker, slot store and result register.
module dhoat_dp #(
	parameter int SLOT_DEPTH = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dhoat_pkg::cmd_t               cmd,
	output dhoat_pkg::sts_t               sts,
	input  logic                          cfg_we,
	input  logic [dhoat_pkg::SIZE_W-1:0]  cfg_wdata,
	input  logic [1:0]                    in_kind,
	input  logic [dhoat_pkg::KEY_W-1:0]   in_key,
	input  logic [dhoat_pkg::LEN_W-1:0]   in_len,
	input  logic [dhoat_pkg::VALUE_BITS-1:0] in_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    out_status,
	output logic [dhoat_pkg::VALUE_BITS-1:0] out_found,
	output logic [dhoat_pkg::SIZE_W-1:0]  out_live
);
	import dhoat_pkg::*;

	localparam int AW = $clog2(SLOT_DEPTH);
	localparam int DEPTH_CAP = (SLOT_DEPTH < 127) ? SLOT_DEPTH : 127;
	localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(DEPTH_CAP);
	localparam logic [AW-1:0] CLR_LAST = AW'(SLOT_DEPTH - 1);

	logic [SIZE_W-1:0] tsize_q, occ_q, size_q, size_d;
	logic [AW-1:0] clr_q;
	kind_t kind_q;
	logic [KEY_W-1:0] key_q, hkey_q, key_m;
	logic [LEN_W-1:0] len_q, bcnt_q, len_sat;
	logic [VALUE_BITS-1:0] val_q, found_q;
	logic skip_q;
	logic [31:0] fnv_q, oat_q;
	logic [31:0] oat_a, oat_b, fin_a, fin_b, fin_c;
	logic [31:0] dva_q, dvb_q;
	logic [SIZE_W-1:0] rema_q, remb_q, sizem1;
	logic [7:0] ta, tb;
	logic [4:0] dcnt_q;
	logic [SIZE_W-1:0] idx_q, step_q, pcnt_q, fd_idx_q, sel_idx_q;
	logic fd_v_q, hit_q, sel_full_q;
	logic [SIZE_W:0] nxt;
	logic [11:0] load_lhs, load_rhs;
	logic [1:0] res_q;
	logic [ENTRY_W-1:0] rdata, wdata;
	logic [1:0] rd_st;
	logic rd_match, ram_we;
	logic [AW-1:0] waddr;

	always_comb begin
		size_d = tsize_q;
		if (size_d > SIZE_CAP) size_d = SIZE_CAP;
		if (size_d < SIZE_W'(3)) size_d = SIZE_W'(3);
		len_sat = (in_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : in_len;
		for (int b = 0; b < KEY_BYTES; b++) begin
			key_m[b*8 +: 8] = (LEN_W'(b) < len_sat) ? in_key[b*8 +: 8] : 8'd0;
		end
		load_lhs = 12'({1'b0, occ_q} + 8'd1) * 12'(LOAD_DEN);
		load_rhs = 12'(size_d) * 12'(LOAD_NUM);
	end

	always_comb begin
		oat_a = oat_q + {24'd0, hkey_q[7:0]};
		oat_a = oat_a + (oat_a << 10);
		oat_b = oat_a ^ (oat_a >> 6);
		fin_a = oat_q + (oat_q << 3);
		fin_b = fin_a ^ (fin_a >> 11);
		fin_c = fin_b + (fin_b << 15);
		sizem1 = size_q - SIZE_W'(1);
		ta = {rema_q, dva_q[31]};
		tb = {remb_q, dvb_q[31]};
		if (ta >= {1'b0, size_q}) ta = ta - {1'b0, size_q};
		if (tb >= {1'b0, sizem1}) tb = tb - {1'b0, sizem1};
		nxt = {1'b0, idx_q} + {1'b0, step_q};
		if (nxt >= {1'b0, size_q}) nxt = nxt - {1'b0, size_q};
	end

	assign rd_st = rdata[1:0];
	assign rd_match = (rd_st == SLOT_FULL) && (rdata[KEY_W+2 +: LEN_W] == len_q)
		&& (rdata[2 +: KEY_W] == key_q);

	always_comb begin
		sts.clr_done   = (clr_q == CLR_LAST);
		sts.skip       = skip_q;
		sts.hash_done  = (bcnt_q == len_q);
		sts.div_done   = (dcnt_q == 5'd31);
		sts.probe_stop = (rd_st == SLOT_EMPTY) || rd_match || (pcnt_q + SIZE_W'(1) == size_q);
		sts.out_free   = !out_valid || out_ready;
	end

	always_comb begin
		ram_we = cmd.clr_en;
		waddr  = clr_q;
		wdata  = '0;
		if (cmd.commit) begin
			waddr = AW'(sel_idx_q);
			unique case (kind_q)
				KIND_INSERT: begin
					ram_we = hit_q;
					wdata  = {val_q, len_q, key_q, SLOT_FULL};
				end
				KIND_REMOVE: begin
					ram_we = hit_q && sel_full_q;
					wdata  = {val_q, len_q, key_q, SLOT_DEAD};
				end
				default: ram_we = 1'b0;
			endcase
		end
	end

	dhoat_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_DEPTH)) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.probe_rd),
		.raddr (AW'(idx_q)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q   <= SIZE_W'(31);
			occ_q     <= '0;
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) tsize_q <= cfg_wdata;
			if (cmd.clr_en) clr_q <= clr_q + AW'(1);
			if (cmd.commit) begin
				if (kind_q == KIND_INSERT && hit_q && !sel_full_q) begin
					occ_q <= occ_q + SIZE_W'(1);
				end
				if (kind_q == KIND_REMOVE && hit_q && sel_full_q && occ_q != '0) begin
					occ_q <= occ_q - SIZE_W'(1);
				end
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q  <= kind_t'(in_kind);
			key_q   <= key_m;
			hkey_q  <= key_m;
			len_q   <= len_sat;
			val_q   <= in_value;
			size_q  <= size_d;
			bcnt_q  <= '0;
			fnv_q   <= FNV_BASIS;
			oat_q   <= '0;
			found_q <= '0;
			skip_q  <= (kind_t'(in_kind) == KIND_NONE)
				|| (kind_t'(in_kind) == KIND_INSERT && load_lhs >= load_rhs);
			res_q   <= (kind_t'(in_kind) == KIND_INSERT && load_lhs >= load_rhs)
				? RES_REFUSED : RES_OK;
		end
		if (cmd.hash_step) begin
			fnv_q  <= (fnv_q ^ {24'd0, hkey_q[7:0]}) * FNV_PRIME;
			oat_q  <= oat_b;
			hkey_q <= hkey_q >> 8;
			bcnt_q <= bcnt_q + LEN_W'(1);
		end
		if (cmd.hash_final) begin
			dva_q  <= fnv_q;
			dvb_q  <= fin_c;
			rema_q <= '0;
			remb_q <= '0;
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			rema_q <= ta[SIZE_W-1:0];
			remb_q <= tb[SIZE_W-1:0];
			dva_q  <= dva_q << 1;
			dvb_q  <= dvb_q << 1;
			dcnt_q <= dcnt_q + 5'd1;
		end
		if (cmd.probe_init) begin
			idx_q  <= rema_q;
			step_q <= remb_q + SIZE_W'(1);
			pcnt_q <= '0;
			fd_v_q <= 1'b0;
		end
		if (cmd.probe_ev) begin
			if (rd_st == SLOT_DEAD && !fd_v_q) begin
				fd_v_q   <= 1'b1;
				fd_idx_q <= idx_q;
			end
			if (rd_st == SLOT_EMPTY) begin
				hit_q      <= 1'b1;
				sel_full_q <= 1'b0;
				sel_idx_q  <= fd_v_q ? fd_idx_q : idx_q;
			end else if (rd_match) begin
				hit_q      <= 1'b1;
				sel_full_q <= 1'b1;
				sel_idx_q  <= idx_q;
				found_q    <= rdata[KEY_W+LEN_W+2 +: VALUE_BITS];
			end else begin
				hit_q      <= 1'b0;
				sel_full_q <= 1'b0;
			end
			idx_q  <= nxt[SIZE_W-1:0];
			pcnt_q <= pcnt_q + SIZE_W'(1);
		end
		if (cmd.commit) begin
			unique case (kind_q)
				KIND_INSERT: res_q <= hit_q ? RES_OK : RES_EXHAUST;
				KIND_LOOKUP: res_q <= !hit_q ? RES_EXHAUST : (sel_full_q ? RES_OK : RES_MISS);
				default:     res_q <= RES_OK;
			endcase
			if (!(kind_q == KIND_LOOKUP && hit_q && sel_full_q)) found_q <= '0;
		end
		if (cmd.out_load) begin
			out_status <= res_q;
			out_found  <= found_q;
			out_live   <= occ_q;
		end
	end
endmodule

// ===== sv/double_hash_open_address_table.sv =====
// One operation at a time; the next is accepted once the last result is loaded for output.
// Work per operation: byte-serial hashing, bit-serial remainder units (32 steps), probe walk.
// Kind 3 and refused inserts go from the hash state straight to the result, skipping the rest.
// Reset: asynchronous; afterwards every slot of the store is cleared before input is accepted.
// The result register lets a new operation start while the last result waits.
module double_hash_open_address_table #(
	parameter int SLOT_DEPTH = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata,      // table_size
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [103:0] s_axis_tdata,   // key_bytes[63:0], key_len[67:64], new_value[99:68]
	input  logic [1:0]   s_axis_tuser,   // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [47:0]  m_axis_tdata    // status[1:0], found_value[33:2], live_count[40:34]
);
	import dhoat_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [1:0] status;
	logic [VALUE_BITS-1:0] found;
	logic [SIZE_W-1:0] live;

	dhoat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dhoat_dp #(.SLOT_DEPTH(SLOT_DEPTH)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_kind    (s_axis_tuser),
		.in_key     (s_axis_tdata[63:0]),
		.in_len     (s_axis_tdata[67:64]),
		.in_value   (s_axis_tdata[99:68]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (status),
		.out_found  (found),
		.out_live   (live)
	);

	assign m_axis_tdata = {7'd0, live, found, status};
endmodule
